@@ rtl/rms_pkg.sv @@
// shared widths, field offsets, key select codes and controller command bundle
package rms_pkg;

   localparam int MAX_RECORDS_DEF = 64;

   localparam int HANDLE_W = 6;
   localparam int ID_W     = 32;
   localparam int TIME_W   = 38;
   localparam int TYPE_W   = 8;
   localparam int KEY_W    = 40;
   localparam int ENTRY_W  = KEY_W + HANDLE_W;
   localparam int SEL_W    = 2;

   localparam int HANDLE_LSB = 0;
   localparam int ID_LSB     = HANDLE_LSB + HANDLE_W;
   localparam int START_LSB  = ID_LSB + ID_W;
   localparam int SP_BIT     = START_LSB + TIME_W;
   localparam int END_LSB    = SP_BIT + 1;
   localparam int EP_BIT     = END_LSB + TIME_W;
   localparam int TYPE_LSB   = EP_BIT + 1;
   localparam int REQ_FIELDS_W = TYPE_LSB + TYPE_W;

   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((HANDLE_W + 7) / 8) * 8;

   typedef enum logic [SEL_W-1:0] {
      KEY_ID    = 2'd0,
      KEY_START = 2'd1,
      KEY_END   = 2'd2,
      KEY_TYPE  = 2'd3
   } key_sel_type;

   typedef struct packed {
      logic load_we;
      logic merge_we;
      logic wr_bank;
      logic rd_bank;
      logic take_left;
      logic out_load;
      logic out_final;
   } cmd_type;

endpackage

@@ rtl/rms_ram.sv @@
// generic ram, one write port and two registered read ports
module rms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/rms_datapath.sv @@
// key forming, two ram banks, key compare and result word register
module rms_datapath #(
   parameter int MAX_RECORDS = rms_pkg::MAX_RECORDS_DEF,
   localparam int AW = $clog2(MAX_RECORDS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rms_pkg::SEL_W-1:0]        csr_wr_data,
   input  logic [rms_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  rms_pkg::cmd_type                 cmd,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [AW-1:0]                    rd_addr_a,
   input  logic [AW-1:0]                    rd_addr_b,
   output logic                             left_le,
   output logic [rms_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   rms_pkg::key_sel_type               sel_ff;
   logic [rms_pkg::HANDLE_W-1:0]       out_handle_ff;
   logic                               out_final_ff;

   logic [rms_pkg::HANDLE_W-1:0]       in_handle;
   logic [rms_pkg::ID_W-1:0]           in_id;
   logic [rms_pkg::TIME_W-1:0]         in_start;
   logic                               in_sp;
   logic [rms_pkg::TIME_W-1:0]         in_end;
   logic                               in_ep;
   logic [rms_pkg::TYPE_W-1:0]         in_type;
   logic [rms_pkg::KEY_W-1:0]          new_key;

   logic [rms_pkg::ENTRY_W-1:0]        rd0_a, rd0_b, rd1_a, rd1_b;
   logic [rms_pkg::ENTRY_W-1:0]        ent_a, ent_b, merge_data;
   logic [rms_pkg::ENTRY_W-1:0]        wr0_data;
   logic                               we0, we1;

   assign in_handle = req_tdata[rms_pkg::HANDLE_LSB +: rms_pkg::HANDLE_W];
   assign in_id     = req_tdata[rms_pkg::ID_LSB +: rms_pkg::ID_W];
   assign in_start  = req_tdata[rms_pkg::START_LSB +: rms_pkg::TIME_W];
   assign in_sp     = req_tdata[rms_pkg::SP_BIT];
   assign in_end    = req_tdata[rms_pkg::END_LSB +: rms_pkg::TIME_W];
   assign in_ep     = req_tdata[rms_pkg::EP_BIT];
   assign in_type   = req_tdata[rms_pkg::TYPE_LSB +: rms_pkg::TYPE_W];

   // absent time sets the bit just above the packed time
   always_comb begin
      unique case (sel_ff)
         rms_pkg::KEY_ID:
            new_key = rms_pkg::KEY_W'({~in_id[rms_pkg::ID_W-1], in_id[rms_pkg::ID_W-2:0]});
         rms_pkg::KEY_START:
            new_key = in_sp ? rms_pkg::KEY_W'(in_start)
                            : rms_pkg::KEY_W'({1'b1, {rms_pkg::TIME_W{1'b0}}});
         rms_pkg::KEY_END:
            new_key = in_ep ? rms_pkg::KEY_W'(in_end)
                            : rms_pkg::KEY_W'({1'b1, {rms_pkg::TIME_W{1'b0}}});
         default:
            new_key = rms_pkg::KEY_W'(in_type);
      endcase
   end

   assign ent_a      = cmd.rd_bank ? rd1_a : rd0_a;
   assign ent_b      = cmd.rd_bank ? rd1_b : rd0_b;
   assign left_le    = ent_a[rms_pkg::ENTRY_W-1:rms_pkg::HANDLE_W]
                       <= ent_b[rms_pkg::ENTRY_W-1:rms_pkg::HANDLE_W];
   assign merge_data = cmd.take_left ? ent_a : ent_b;

   assign we0      = cmd.load_we | (cmd.merge_we & ~cmd.wr_bank);
   assign we1      = cmd.merge_we & cmd.wr_bank;
   assign wr0_data = cmd.load_we ? {new_key, in_handle} : merge_data;

   rms_ram #(
      .WIDTH (rms_pkg::ENTRY_W),
      .DEPTH (MAX_RECORDS)
   ) u_bank0 (
      .clock     (clock),
      .wr_en     (we0),
      .wr_addr   (wr_addr),
      .wr_data   (wr0_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd0_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd0_b)
   );

   rms_ram #(
      .WIDTH (rms_pkg::ENTRY_W),
      .DEPTH (MAX_RECORDS)
   ) u_bank1 (
      .clock     (clock),
      .wr_en     (we1),
      .wr_addr   (wr_addr),
      .wr_data   (merge_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd1_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd1_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= rms_pkg::KEY_ID;
      end else if (csr_wr_en) begin
         sel_ff <= rms_pkg::key_sel_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_handle_ff <= ent_a[rms_pkg::HANDLE_W-1:0];
         out_final_ff  <= cmd.out_final;
      end
   end

   assign rsp_tdata = rms_pkg::RSP_TDATA_W'(out_handle_ff);
   assign rsp_tlast = out_final_ff;

endmodule

@@ rtl/rms_ctrl.sv @@
// load, merge pass and output sequencing state machine
module rms_ctrl #(
   parameter int MAX_RECORDS = rms_pkg::MAX_RECORDS_DEF,
   localparam int AW = $clog2(MAX_RECORDS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              left_le,
   output rms_pkg::cmd_type  cmd,
   output logic [AW-1:0]     wr_addr,
   output logic [AW-1:0]     rd_addr_a,
   output logic [AW-1:0]     rd_addr_b
);

   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int SW = CW + 2;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECORDS);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BLOCK,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_SEND
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SW-1:0]   width_ff, width_in;
   logic [SW-1:0]   lo_ff, lo_in;
   logic [SW-1:0]   mid_ff, mid_in;
   logic [SW-1:0]   hi_ff, hi_in;
   logic [SW-1:0]   i_ff, i_in;
   logic [SW-1:0]   j_ff, j_in;
   logic [SW-1:0]   k_ff, k_in;
   logic            bank_ff, bank_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]   n_wide, sum_mid, sum_hi, width_dbl, k_next;
   logic            take_left;

   assign n_wide    = SW'(count_ff);
   assign sum_mid   = lo_ff + width_ff;
   assign width_dbl = width_ff << 1;
   assign sum_hi    = lo_ff + width_dbl;
   assign k_next    = k_ff + SW'(1);
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || left_le);

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign wr_addr    = (state_ff == ST_LOAD) ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign rd_addr_a  = (state_ff == ST_OUT_RD) ? k_ff[AW-1:0] : i_ff[AW-1:0];
   assign rd_addr_b  = j_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      width_in      = width_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      bank_in       = bank_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      cmd.rd_bank   = bank_ff;
      cmd.wr_bank   = ~bank_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < MAX_COUNT) begin
                  cmd.load_we = 1'b1;
                  count_in    = count_ff + CW'(1);
               end
               if (req_tlast) begin
                  width_in = SW'(1);
                  lo_in    = '0;
                  k_in     = '0;
                  bank_in  = 1'b0;
                  state_in = (count_in > CW'(1)) ? ST_BLOCK : ST_OUT_RD;
               end
            end
         end
         ST_BLOCK: begin
            mid_in   = (sum_mid > n_wide) ? n_wide : sum_mid;
            hi_in    = (sum_hi > n_wide) ? n_wide : sum_hi;
            i_in     = lo_ff;
            j_in     = mid_in;
            state_in = ST_MERGE_RD;
         end
         ST_MERGE_RD: begin
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_we  = 1'b1;
            cmd.take_left = take_left;
            if (take_left) begin
               i_in = i_ff + SW'(1);
            end else begin
               j_in = j_ff + SW'(1);
            end
            k_in = k_next;
            if (k_next == hi_ff) begin
               if (hi_ff == n_wide) begin
                  bank_in  = ~bank_ff;
                  width_in = width_dbl;
                  lo_in    = '0;
                  k_in     = '0;
                  state_in = (width_dbl >= n_wide) ? ST_OUT_RD : ST_BLOCK;
               end else begin
                  lo_in    = hi_ff;
                  state_in = ST_BLOCK;
               end
            end else begin
               state_in = ST_MERGE_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            cmd.out_load  = 1'b1;
            cmd.out_final = (k_next == n_wide);
            rsp_valid_in  = 1'b1;
            state_in      = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (k_next == n_wide) begin
                  count_in = '0;
                  bank_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_next;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         width_ff     <= SW'(1);
         lo_ff        <= '0;
         mid_ff       <= '0;
         hi_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         lo_ff        <= lo_in;
         mid_ff       <= mid_in;
         hi_ff        <= hi_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/record_merge_sorter.sv @@
// top level of the record merge sorter
//
// Records are taken one per cycle while the block is loading; only the key picked by
// csr_wr_data (0 id, 1 start time, 2 end time, 3 type) is stored with the handle, in one
// of two ping-pong ram banks. A word with tlast starts a stable bottom-up merge sort of
// the n stored records: ceil(log2 n) passes, each record taking one ram read of both run
// heads and then one compare and write, as the two-port ram read is registered, and each
// merged block starting with a set-up step. Handles then leave in ascending key order, each
// word read from ram only once the one before is accepted, the last one with tlast. No record
// is taken from the tlast word until the last handle is delivered. Records past MAX_RECORDS are
// dropped, but their tlast still starts the sort.
module record_merge_sorter #(
   parameter int MAX_RECORDS = rms_pkg::MAX_RECORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rms_pkg::SEL_W-1:0]        csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // record_handle, record_id, start_time, start_present, end_time, end_present, work_type
   input  logic [rms_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sorted_handle
   output logic [rms_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(MAX_RECORDS);

   rms_pkg::cmd_type  cmd;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   logic              left_le;

   rms_ctrl #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .left_le    (left_le),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b)
   );

   rms_datapath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .left_le     (left_le),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ rtl/rms_checker.sv @@
// port level checks on the record merge sorter, bound to the top level
module rms_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_wr_en,
   input logic [rms_pkg::SEL_W-1:0]        csr_wr_data,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [rms_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rms_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);

   // ready to load right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

   // no loading while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading while a result word is shown");

   // last record closes the input until the run is out
   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after last record");

   // final result word reopens the input
   a_reopen_on_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("input not reopened after final word");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind record_merge_sorter rms_checker u_rms_checker (.*);
